// ===== hdl/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, constants and the keyword table of the script byte tokenizer.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int WORD_MAX_DEF  = 16;
  localparam int KEYWORD_COUNT = 39;
  localparam int KW_CHARS      = 14;
  localparam int LINE_W        = 24;
  localparam int MAX_RES       = 3;

  localparam logic [LINE_W-1:0] LINE_TOP = {LINE_W{1'b1}};

  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_IDENT   = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_SYMBOL  = 3'd4;
  localparam logic [2:0] KIND_EOF     = 3'd5;

  typedef logic [KW_CHARS-1:0][7:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KEYWORD_COUNT] = '{
    kw_text_t'("var"), kw_text_t'("scene"), kw_text_t'("sprite"), kw_text_t'("choice"),
    kw_text_t'("jump"), kw_text_t'("if"), kw_text_t'("and"), kw_text_t'("or"),
    kw_text_t'("true"), kw_text_t'("false"), kw_text_t'("bg"), kw_text_t'("bgm"),
    kw_text_t'("sfx"), kw_text_t'("ui"), kw_text_t'("halt"), kw_text_t'("return"),
    kw_text_t'("call"), kw_text_t'("local"), kw_text_t'("wait"), kw_text_t'("shake"),
    kw_text_t'("delay"), kw_text_t'("expression"), kw_text_t'("hide"), kw_text_t'("pos"),
    kw_text_t'("clear"), kw_text_t'("random"), kw_text_t'("fade"), kw_text_t'("move"),
    kw_text_t'({"fade_", "screen"}), kw_text_t'("narration"), kw_text_t'("alias"),
    kw_text_t'("timeline"), kw_text_t'("play"), kw_text_t'("leave"), kw_text_t'("event"),
    kw_text_t'("emit"), kw_text_t'("parallel"), kw_text_t'("await"),
    kw_text_t'({"play_", "sequence"})
  };

  localparam int KW_LEN [KEYWORD_COUNT] = '{
    3, 5, 6, 6, 4, 2, 3, 2, 4, 5, 2, 3, 3, 2, 4, 6, 4, 5, 4, 5,
    5, 10, 4, 3, 5, 6, 4, 4, 11, 9, 5, 8, 4, 5, 5, 4, 8, 5, 13
  };

  typedef struct packed {
    logic              has_char;
    logic [7:0]        text_char;
    logic              token_end;
    logic [2:0]        token_kind;
    logic [LINE_W-1:0] line_number;
  } rec_t;

  typedef struct packed {
    logic [1:0]         cnt;
    rec_t [MAX_RES-1:0] rec;
  } bundle_t;

endpackage

// ===== hdl/sbt_front.sv =====
// ----------------------------------------------------------------------------
// sbt_front
// Scanner: classifies each byte and produces the bundle of results it causes.
// ----------------------------------------------------------------------------
module sbt_front #(
  parameter int WORD_MAX = sbt_pkg::WORD_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       char_i,
  input  logic             eos_i,
  output logic             push_o,
  output sbt_pkg::bundle_t bundle_o,
  input  logic             full_i
);
  import sbt_pkg::*;

  localparam int LEN_W = $clog2(WORD_MAX + 2);
  localparam int IDX_W = $clog2(WORD_MAX);

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_COMMENT = 7'b0000010,
    M_NUM     = 7'b0000100,
    M_NUMSUF  = 7'b0001000,
    M_WORD    = 7'b0010000,
    M_STR     = 7'b0100000,
    M_STRESC  = 7'b1000000
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [7:0]        held_q, held_d;
  logic              pend_q, pend_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [LEN_W-1:0]  wlen_q, wlen_d;
  logic [7:0]        wbuf_q [WORD_MAX];
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [KEYWORD_COUNT-1:0] kw_hit;
  logic [2:0]        word_kind;
  bundle_t           b;
  logic              fire;

  function automatic bundle_t push(bundle_t bi, rec_t r);
    bundle_t bo;
    bo = bi;
    if (bi.cnt < 2'(MAX_RES)) begin
      bo.rec[bi.cnt] = r;
      bo.cnt = bi.cnt + 2'd1;
    end
    return bo;
  endfunction

  function automatic rec_t ch_rec(logic [7:0] c);
    rec_t r;
    r = '0;
    r.has_char = 1'b1;
    r.text_char = c;
    return r;
  endfunction

  function automatic rec_t end_rec(logic [2:0] k, logic [LINE_W-1:0] ln);
    rec_t r;
    r = '0;
    r.token_end = 1'b1;
    r.token_kind = k;
    r.line_number = ln;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  always_comb begin
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      kw_hit[k] = (wlen_q == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_CHARS - 1; i++) begin
        if (i < KW_LEN[k]) begin
          if (wbuf_q[i] != KW_TEXT[k][KW_LEN[k] - 1 - i]) kw_hit[k] = 1'b0;
        end
      end
    end
    word_kind = (wlen_q <= LEN_W'(WORD_MAX) && |kw_hit) ? KIND_KEYWORD : KIND_IDENT;
  end

  assign ready_o = !full_i;
  assign fire    = valid_i && ready_o;

  always_comb begin
    logic restart;
    logic [7:0] c;
    restart = 1'b0;
    c = char_i;
    b = '0;
    mode_d = mode_q;
    held_d = held_q;
    pend_d = pend_q;
    line_d = line_q;
    wlen_d = wlen_q;
    wr_en = 1'b0;
    wr_idx = wlen_q[IDX_W-1:0];
    if (eos_i) begin
      if (pend_q) b = push(b, end_rec(KIND_SYMBOL, line_q));
      unique case (mode_q)
        M_NUM, M_NUMSUF: b = push(b, end_rec(KIND_NUMBER, line_q));
        M_WORD:          b = push(b, end_rec(word_kind, line_q));
        M_STR:           b = push(b, end_rec(KIND_STRING, line_q));
        M_STRESC: begin
          b = push(b, ch_rec("\\"));
          b = push(b, end_rec(KIND_STRING, line_q));
        end
        default: ;
      endcase
      b = push(b, end_rec(KIND_EOF, line_q));
      mode_d = M_IDLE;
      pend_d = 1'b0;
      held_d = '0;
      wlen_d = '0;
      line_d = LINE_W'(1);
    end else if (pend_q) begin
      pend_d = 1'b0;
      if (c == "=" || (held_q == "-" && (c == ">" || c == "-")) ||
          (held_q == "+" && c == "+")) begin
        b = push(b, ch_rec(c));
        b = push(b, end_rec(KIND_SYMBOL, line_q));
      end else begin
        b = push(b, end_rec(KIND_SYMBOL, line_q));
        restart = 1'b1;
      end
    end else begin
      unique case (mode_q)
        M_COMMENT: begin
          if (c == 8'h0A) begin
            mode_d = M_IDLE;
            if (line_q != LINE_TOP) line_d = line_q + 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c) || c == ".") b = push(b, ch_rec(c));
          else if (is_alpha(c)) begin
            b = push(b, ch_rec(c));
            mode_d = M_NUMSUF;
          end else begin
            b = push(b, end_rec(KIND_NUMBER, line_q));
            restart = 1'b1;
          end
        end
        M_NUMSUF: begin
          if (is_alpha(c) || is_digit(c)) b = push(b, ch_rec(c));
          else begin
            b = push(b, end_rec(KIND_NUMBER, line_q));
            restart = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            b = push(b, ch_rec(c));
            wr_en = (wlen_q < LEN_W'(WORD_MAX));
            if (wlen_q <= LEN_W'(WORD_MAX)) wlen_d = wlen_q + 1'b1;
          end else begin
            b = push(b, end_rec(word_kind, line_q));
            restart = 1'b1;
          end
        end
        M_STR: begin
          if (c == "\"") begin
            b = push(b, end_rec(KIND_STRING, line_q));
            mode_d = M_IDLE;
          end else if (c == "\\") mode_d = M_STRESC;
          else b = push(b, ch_rec(c));
        end
        M_STRESC: begin
          b = push(b, ch_rec(c));
          mode_d = M_STR;
        end
        default: restart = 1'b1;
      endcase
    end
    if (restart) begin
      mode_d = M_IDLE;
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
        if (c == 8'h0A && line_q != LINE_TOP) line_d = line_q + 1'b1;
      end else if (c == "#") begin
        mode_d = M_COMMENT;
      end else if (is_digit(c)) begin
        b = push(b, ch_rec(c));
        mode_d = M_NUM;
      end else if (is_alpha(c) || c == "_") begin
        b = push(b, ch_rec(c));
        wr_en = 1'b1;
        wr_idx = '0;
        wlen_d = LEN_W'(1);
        mode_d = M_WORD;
      end else if (c == "\"") begin
        mode_d = M_STR;
      end else if (c == "-" || c == "+" || c == "*" || c == "/" ||
                   c == "=" || c == "!" || c == ">" || c == "<") begin
        b = push(b, ch_rec(c));
        held_d = c;
        pend_d = 1'b1;
      end else begin
        b = push(b, ch_rec(c));
        b = push(b, end_rec(KIND_SYMBOL, line_q));
      end
    end
  end

  assign push_o   = fire && (b.cnt != 2'd0);
  assign bundle_o = b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      held_q <= '0;
      pend_q <= 1'b0;
      line_q <= LINE_W'(1);
      wlen_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      held_q <= held_d;
      pend_q <= pend_d;
      line_q <= line_d;
      wlen_q <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && !eos_i && wr_en) wbuf_q[wr_idx] <= char_i;
  end

endmodule

// ===== hdl/sbt_fifo.sv =====
// ----------------------------------------------------------------------------
// sbt_fifo
// Two-entry queue of result bundles between scanner and emitter.
// ----------------------------------------------------------------------------
module sbt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbt_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output sbt_pkg::bundle_t data_o
);
  import sbt_pkg::*;

  bundle_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

// ===== hdl/sbt_emit.sv =====
// ----------------------------------------------------------------------------
// sbt_emit
// Emitter: sends the results of each queued bundle one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module sbt_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  sbt_pkg::bundle_t data_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output sbt_pkg::rec_t    rec_o,
  output logic             last_o
);
  import sbt_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  rec_t       rec_q;
  logic       last_q;
  logic       load;
  logic       is_last;

  assign load    = (!valid_q || ready_i) && !empty_i;
  assign is_last = (idx_q == data_i.cnt - 2'd1);
  assign pop_o   = load && is_last;
  assign valid_o = valid_q;
  assign rec_o   = rec_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q  <= data_i.rec[idx_q];
      last_q <= is_last;
    end
  end

endmodule

// ===== hdl/script_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// script_byte_tokenizer
// Streaming tokenizer: source bytes in, token characters and token ends out.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata                     | tuser                | tlast
// s_axis  | in        | [7:0] char                | -                    | end of source
// m_axis  | out       | [7:0] char, [31:8] line   | [0] char, [1] end,   | last result
//         |           |                           | [4:2] kind           |
// The scanner takes one byte per cycle while the two-bundle queue has room.
// Each byte gives zero to three results; the emitter sends one per cycle
// while m_axis_tready is high and the queue is not empty.
// After reset the line count is one and the scanner is between tokens.
// Either side may stall without stopping the other until the queue fills or drains.
// ----------------------------------------------------------------------------
module script_byte_tokenizer #(
  parameter int WORD_MAX = sbt_pkg::WORD_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_value
  input  logic        s_axis_tlast,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] text_char, [31:8] line_number
  output logic [4:0]  m_axis_tuser,   // [0] has_char, [1] token_end, [4:2] token_kind
  output logic        m_axis_tlast    // last_result_of_byte
);
  import sbt_pkg::*;

  logic    push, full, pop, empty;
  bundle_t in_b, out_b;
  rec_t    rec;

  sbt_front #(.WORD_MAX(WORD_MAX)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .char_i   (s_axis_tdata),
    .eos_i    (s_axis_tlast),
    .push_o   (push),
    .bundle_o (in_b),
    .full_i   (full)
  );

  sbt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_b),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_b)
  );

  sbt_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (out_b),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rec_o   (rec),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {rec.line_number, rec.text_char};
  assign m_axis_tuser = {rec.token_kind, rec.token_end, rec.has_char};

endmodule
